FILE: sv/cpag_pkg.sv
// ---------------------------------------------------------------------------
// cpag_pkg
// Shared types, widths and the square-root step for the cuboid patch
// address generator.
// ---------------------------------------------------------------------------
package cpag_pkg;

    localparam int COORD_W   = 10;
    localparam int SIZE_W    = 11;
    localparam int SPACE_W   = 16;
    localparam int PROD_W    = COORD_W + SPACE_W;      // |d| * spacing
    localparam int AXSQ_W    = 2 * PROD_W;             // per-axis square
    localparam int SUM_W     = AXSQ_W + 2;             // sum of three squares
    localparam int SQ_W      = 36;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int REM_W     = ROOT_W + 3;
    localparam int ROOT_STG  = ROOT_W / 2;             // two root bits per stage
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X    = 3'd0,
        CFG_SIZE_Y    = 3'd1,
        CFG_SIZE_Z    = 3'd2,
        CFG_SPACING_X = 3'd3,
        CFG_SPACING_Y = 3'd4,
        CFG_SPACING_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic first;
        logic last;
    } t_flags;

    typedef struct packed {
        logic [COORD_W-1:0] nb_x;
        logic [COORD_W-1:0] nb_y;
        logic [COORD_W-1:0] nb_z;
        logic [SQ_W-1:0]    sq;
        logic               last;
    } t_item;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt;

    // One digit of the restoring square root: bring down two radicand bits.
    function automatic t_sqrt sqrt_step(input t_sqrt cur, input logic [1:0] pair);
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        t_sqrt            res;
        rem_sh = {cur.rem[REM_W-3:0], pair};
        trial  = REM_W'({cur.root, 2'b01});
        if (rem_sh >= trial) begin
            res.rem  = rem_sh - trial;
            res.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
            res.rem  = rem_sh;
            res.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

FILE: sv/cpag_seq.sv
// ---------------------------------------------------------------------------
// cpag_seq
// Offset sequencer: holds one centre and walks the cuboid offsets, x
// innermost, one offset per advance.
// ---------------------------------------------------------------------------
module cpag_seq import cpag_pkg::*; #(
    parameter int HALF_X = 1,
    parameter int HALF_Y = 1,
    parameter int HALF_Z = 1,
    parameter int CW_X   = 2,
    parameter int CW_Y   = 2,
    parameter int CW_Z   = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [COORD_W-1:0] i_cx,
    input  logic [COORD_W-1:0] i_cy,
    input  logic [COORD_W-1:0] i_cz,
    input  logic               i_adv,
    output logic               o_ready,
    output logic               o_valid,
    output logic [COORD_W-1:0] o_cx,
    output logic [COORD_W-1:0] o_cy,
    output logic [COORD_W-1:0] o_cz,
    output logic [CW_X-1:0]    o_cnt_x,
    output logic [CW_Y-1:0]    o_cnt_y,
    output logic [CW_Z-1:0]    o_cnt_z,
    output t_flags             o_flags
);

    localparam logic [CW_X-1:0] MAX_X = CW_X'(2 * HALF_X);
    localparam logic [CW_Y-1:0] MAX_Y = CW_Y'(2 * HALF_Y);
    localparam logic [CW_Z-1:0] MAX_Z = CW_Z'(2 * HALF_Z);

    logic               r_busy;
    logic [COORD_W-1:0] r_cx, r_cy, r_cz;
    logic [CW_X-1:0]    r_ox;
    logic [CW_Y-1:0]    r_oy;
    logic [CW_Z-1:0]    r_oz;
    logic               w_last;
    logic               w_load;

    assign w_last  = (r_ox == MAX_X) && (r_oy == MAX_Y) && (r_oz == MAX_Z);
    assign o_ready = !r_busy || (i_adv && w_last);
    assign w_load  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_load) begin
            r_busy <= 1'b1;
        end else if (r_busy && i_adv && w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cx <= i_cx;
            r_cy <= i_cy;
            r_cz <= i_cz;
            r_ox <= '0;
            r_oy <= '0;
            r_oz <= '0;
        end else if (r_busy && i_adv && !w_last) begin
            // x innermost, then y, then z
            if (r_ox != MAX_X) begin
                r_ox <= r_ox + CW_X'(1);
            end else begin
                r_ox <= '0;
                if (r_oy != MAX_Y) begin
                    r_oy <= r_oy + CW_Y'(1);
                end else begin
                    r_oy <= '0;
                    r_oz <= r_oz + CW_Z'(1);
                end
            end
        end
    end

    assign o_valid       = r_busy;
    assign o_cx          = r_cx;
    assign o_cy          = r_cy;
    assign o_cz          = r_cz;
    assign o_cnt_x       = r_ox;
    assign o_cnt_y       = r_oy;
    assign o_cnt_z       = r_oz;
    assign o_flags.first = (r_ox == '0) && (r_oy == '0) && (r_oz == '0);
    assign o_flags.last  = w_last;

endmodule

FILE: sv/cpag_axis.sv
// ---------------------------------------------------------------------------
// cpag_axis
// One axis: fold the neighbour at the image border, scale the distance by
// the spacing and square it. Three register stages.
// ---------------------------------------------------------------------------
module cpag_axis import cpag_pkg::*; #(
    parameter int HALF = 1,
    parameter int CW   = 2
) (
    input  logic               i_clk,
    input  logic [3:1]         i_en,
    input  logic [COORD_W-1:0] i_centre,
    input  logic [CW-1:0]      i_cnt,
    input  logic [SIZE_W-1:0]  i_size,
    input  logic [SPACE_W-1:0] i_spacing,
    output logic [COORD_W-1:0] o_nb,
    output logic [AXSQ_W-1:0]  o_sq
);

    localparam int SW = SIZE_W + 2;

    logic signed [SW-1:0] w_off, w_c, w_f, w_size;
    logic [COORD_W-1:0]   w_d;

    logic [COORD_W-1:0]   r_nb1, r_c1, r_nb2, r_nb3;
    logic [PROD_W-1:0]    r_t2;
    logic [AXSQ_W-1:0]    r_sq3;

    always_comb begin
        w_off  = SW'(i_cnt) - SW'(HALF);
        w_size = SW'(i_size);
        w_c    = SW'(i_centre) + w_off;
        w_f    = w_c;
        if (w_c < 0) begin
            w_f = SW'(HALF) - w_off;
        end
        if (w_f >= w_size) begin
            w_f = w_size - SW'(1) - SW'(HALF) - w_off;
        end
    end

    assign w_d = (r_c1 >= r_nb1) ? (r_c1 - r_nb1) : (r_nb1 - r_c1);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_nb1 <= w_f[COORD_W-1:0];
            r_c1  <= i_centre;
        end
        if (i_en[2]) begin
            r_nb2 <= r_nb1;
            r_t2  <= PROD_W'(w_d) * PROD_W'(i_spacing);
        end
        if (i_en[3]) begin
            r_nb3 <= r_nb2;
            r_sq3 <= AXSQ_W'(r_t2) * AXSQ_W'(r_t2);
        end
    end

    assign o_nb = r_nb3;
    assign o_sq = r_sq3;

endmodule

FILE: sv/cpag_root.sv
// ---------------------------------------------------------------------------
// cpag_root
// Pipelined integer square root, two root bits per stage; the result item
// travels alongside.
// ---------------------------------------------------------------------------
module cpag_root import cpag_pkg::*; (
    input  logic               i_clk,
    input  logic [ROOT_STG:1]  i_en,
    input  t_item              i_item,
    input  logic [SQ_W-1:0]    i_rad,
    output t_item              o_item,
    output logic [ROOT_W-1:0]  o_root
);

    t_item           r_item [1:ROOT_STG];
    logic [SQ_W-1:0] r_rad  [1:ROOT_STG];
    t_sqrt           r_acc  [1:ROOT_STG];

    t_item           w_item [1:ROOT_STG];
    logic [SQ_W-1:0] w_rad  [1:ROOT_STG];
    t_sqrt           w_acc  [1:ROOT_STG];

    always_comb begin
        t_sqrt mid;
        mid       = sqrt_step('0, i_rad[SQ_W-1:SQ_W-2]);
        w_acc[1]  = sqrt_step(mid, i_rad[SQ_W-3:SQ_W-4]);
        w_rad[1]  = {i_rad[SQ_W-5:0], 4'b0000};
        w_item[1] = i_item;
        for (int s = 2; s <= ROOT_STG; s++) begin
            mid       = sqrt_step(r_acc[s-1], r_rad[s-1][SQ_W-1:SQ_W-2]);
            w_acc[s]  = sqrt_step(mid, r_rad[s-1][SQ_W-3:SQ_W-4]);
            w_rad[s]  = {r_rad[s-1][SQ_W-5:0], 4'b0000};
            w_item[s] = r_item[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 1; s <= ROOT_STG; s++) begin
            if (i_en[s]) begin
                r_item[s] <= w_item[s];
                r_rad[s]  <= w_rad[s];
                r_acc[s]  <= w_acc[s];
            end
        end
    end

    assign o_item = r_item[ROOT_STG];
    assign o_root = r_acc[ROOT_STG].root;

endmodule

FILE: sv/cuboid_patch_address_generator.sv
// ---------------------------------------------------------------------------
// cuboid_patch_address_generator
// Cuboid neighborhood walker with mirrored borders, weighted squared
// distance and root of the largest distance per centre.
// ---------------------------------------------------------------------------
// Each accepted centre produces (2*HALF_X+1)*(2*HALF_Y+1)*(2*HALF_Z+1)
// results, one per cycle while the output is not stalled, so a 3x3x3 patch
// occupies the offset sequencer for 27 offsets; the next centre is taken in
// the cycle the last offset leaves the sequencer, so results stream without
// gaps. Behind the sequencer sits a 14-stage pipeline (fold, scale, square,
// sum, running max, then nine stages of square root at two bits each), which
// every result passes through in that order. Every stage holds under output
// stall and bubbles collapse. Configuration writes are always ready and take
// effect at once; write them only while the block is empty.
// ---------------------------------------------------------------------------
module cuboid_patch_address_generator import cpag_pkg::*; #(
    parameter int HALF_X = 1,
    parameter int HALF_Y = 1,
    parameter int HALF_Z = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [COORD_W-1:0]   i_centre_x,
    input  logic [COORD_W-1:0]   i_centre_y,
    input  logic [COORD_W-1:0]   i_centre_z,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [COORD_W-1:0]   o_nb_x,
    output logic [COORD_W-1:0]   o_nb_y,
    output logic [COORD_W-1:0]   o_nb_z,
    output logic [SQ_W-1:0]      o_sq_dist,
    output logic [ROOT_W-1:0]    o_max_dist,
    output logic                 o_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int CW_X   = (HALF_X > 0) ? $clog2(2 * HALF_X + 1) : 1;
    localparam int CW_Y   = (HALF_Y > 0) ? $clog2(2 * HALF_Y + 1) : 1;
    localparam int CW_Z   = (HALF_Z > 0) ? $clog2(2 * HALF_Z + 1) : 1;
    localparam int ST_AX  = 3;                 // axis stages
    localparam int ST_SUM = ST_AX + 1;
    localparam int ST_MAX = ST_AX + 2;
    localparam int NSTG   = ST_MAX + ROOT_STG;
    localparam logic [SUM_W-1:0] SQ_SAT = SUM_W'({SQ_W{1'b1}});

    // configuration
    logic [SIZE_W-1:0]  r_size_x, r_size_y, r_size_z;
    logic [SPACE_W-1:0] r_spc_x, r_spc_y, r_spc_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_x <= SIZE_W'(256);
            r_size_y <= SIZE_W'(256);
            r_size_z <= SIZE_W'(256);
            r_spc_x  <= SPACE_W'(256);
            r_spc_y  <= SPACE_W'(256);
            r_spc_z  <= SPACE_W'(256);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SIZE_X:    r_size_x <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Y:    r_size_y <= i_cfg_data[SIZE_W-1:0];
                CFG_SIZE_Z:    r_size_z <= i_cfg_data[SIZE_W-1:0];
                CFG_SPACING_X: r_spc_x  <= i_cfg_data;
                CFG_SPACING_Y: r_spc_y  <= i_cfg_data;
                CFG_SPACING_Z: r_spc_z  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // stage valids and load enables
    logic [NSTG:1] r_v;
    logic [NSTG:1] w_en;

    always_comb begin
        w_en[NSTG] = !r_v[NSTG] || !i_out_stall;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    // sequencer
    logic               w_seq_ready, w_seq_valid;
    logic [COORD_W-1:0] w_cx, w_cy, w_cz;
    logic [CW_X-1:0]    w_cnt_x;
    logic [CW_Y-1:0]    w_cnt_y;
    logic [CW_Z-1:0]    w_cnt_z;
    t_flags             w_seq_flags;

    cpag_seq #(
        .HALF_X (HALF_X),
        .HALF_Y (HALF_Y),
        .HALF_Z (HALF_Z),
        .CW_X   (CW_X),
        .CW_Y   (CW_Y),
        .CW_Z   (CW_Z)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_cx    (i_centre_x),
        .i_cy    (i_centre_y),
        .i_cz    (i_centre_z),
        .i_adv   (w_en[1]),
        .o_ready (w_seq_ready),
        .o_valid (w_seq_valid),
        .o_cx    (w_cx),
        .o_cy    (w_cy),
        .o_cz    (w_cz),
        .o_cnt_x (w_cnt_x),
        .o_cnt_y (w_cnt_y),
        .o_cnt_z (w_cnt_z),
        .o_flags (w_seq_flags)
    );

    assign o_in_stall = !w_seq_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= w_seq_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // axis units, stages 1 to 3
    logic [COORD_W-1:0] w_nb_x, w_nb_y, w_nb_z;
    logic [AXSQ_W-1:0]  w_sq_x, w_sq_y, w_sq_z;

    cpag_axis #(.HALF(HALF_X), .CW(CW_X)) u_axis_x (
        .i_clk     (i_clk),
        .i_en      (w_en[ST_AX:1]),
        .i_centre  (w_cx),
        .i_cnt     (w_cnt_x),
        .i_size    (r_size_x),
        .i_spacing (r_spc_x),
        .o_nb      (w_nb_x),
        .o_sq      (w_sq_x)
    );

    cpag_axis #(.HALF(HALF_Y), .CW(CW_Y)) u_axis_y (
        .i_clk     (i_clk),
        .i_en      (w_en[ST_AX:1]),
        .i_centre  (w_cy),
        .i_cnt     (w_cnt_y),
        .i_size    (r_size_y),
        .i_spacing (r_spc_y),
        .o_nb      (w_nb_y),
        .o_sq      (w_sq_y)
    );

    cpag_axis #(.HALF(HALF_Z), .CW(CW_Z)) u_axis_z (
        .i_clk     (i_clk),
        .i_en      (w_en[ST_AX:1]),
        .i_centre  (w_cz),
        .i_cnt     (w_cnt_z),
        .i_size    (r_size_z),
        .i_spacing (r_spc_z),
        .o_nb      (w_nb_z),
        .o_sq      (w_sq_z)
    );

    // flags travel beside the axis stages
    t_flags r_fl [1:ST_SUM];

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_fl[1] <= w_seq_flags;
        end
        for (int k = 2; k <= ST_SUM; k++) begin
            if (w_en[k]) begin
                r_fl[k] <= r_fl[k-1];
            end
        end
    end

    // stage 4: sum and saturate
    logic [SUM_W-1:0] w_sum;
    t_item            r_item4;

    assign w_sum = SUM_W'(w_sq_x) + SUM_W'(w_sq_y) + SUM_W'(w_sq_z);

    always_ff @(posedge i_clk) begin
        if (w_en[ST_SUM]) begin
            r_item4.nb_x <= w_nb_x;
            r_item4.nb_y <= w_nb_y;
            r_item4.nb_z <= w_nb_z;
            r_item4.sq   <= (w_sum > SQ_SAT) ? {SQ_W{1'b1}} : w_sum[SQ_W-1:0];
            r_item4.last <= r_fl[ST_AX].last;
        end
    end

    // stage 5: running maximum over the centre's results
    logic [SQ_W-1:0] r_runmax;
    logic [SQ_W-1:0] n_runmax;
    t_item           r_item5;

    always_comb begin
        if (r_fl[ST_SUM].first || (r_item4.sq > r_runmax)) begin
            n_runmax = r_item4.sq;
        end else begin
            n_runmax = r_runmax;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[ST_MAX] && r_v[ST_SUM]) begin
            r_runmax <= n_runmax;
            r_item5  <= r_item4;
        end
    end

    // stages 6 to 14: root of the running maximum
    t_item             w_out_item;
    logic [ROOT_W-1:0] w_root;

    cpag_root u_root (
        .i_clk  (i_clk),
        .i_en   (w_en[NSTG:ST_MAX+1]),
        .i_item (r_item5),
        .i_rad  (r_runmax),
        .o_item (w_out_item),
        .o_root (w_root)
    );

    assign o_out_valid = r_v[NSTG];
    assign o_nb_x      = w_out_item.nb_x;
    assign o_nb_y      = w_out_item.nb_y;
    assign o_nb_z      = w_out_item.nb_z;
    assign o_sq_dist   = w_out_item.sq;
    assign o_last      = w_out_item.last;
    assign o_max_dist  = w_out_item.last ? w_root : '0;

    // checks
    a_idle_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_seq_valid |-> !o_in_stall)
        else $error("input stalled while sequencer idle");

    a_hold_behind_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTG] && r_v[NSTG-1] && i_out_stall) |=> r_v[NSTG-1])
        else $error("stage dropped behind stalled output");

    a_max_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en[ST_MAX] && r_v[ST_SUM] && r_fl[ST_SUM].first)
            |=> (r_runmax == $past(r_item4.sq)))
        else $error("running maximum not restarted on first offset");

endmodule
